FILE: rtl/s2da_pkg.sv
`timescale 1ns / 1ps

package s2da_pkg;

    localparam int VALUE_W    = 32;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int CNT_W      = 5;
    localparam int IDX_W      = 4;
    localparam int CHAR_W     = 6;

    localparam logic [CNT_W-1:0]  LAST_STEP  = CNT_W'(VALUE_W - 1);
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_LOCATE,
        ST_SIGN,
        ST_DIGITS
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic locate;
        logic emit_sign;
        logic emit_digit;
    } t_dp_cmd;

    typedef struct packed {
        logic conv_done;
        logic is_neg;
        logic idx_zero;
    } t_dp_status;

endpackage

FILE: rtl/s2da_datapath.sv
`timescale 1ns / 1ps

module s2da_datapath (
    input  logic                          i_clk,
    input  logic [s2da_pkg::VALUE_W-1:0]  i_value,
    input  s2da_pkg::t_dp_cmd             i_cmd,
    output s2da_pkg::t_dp_status          o_status,
    output logic [s2da_pkg::CHAR_W-1:0]   o_char_code,
    output logic                          o_last
);
    import s2da_pkg::*;

    logic [VALUE_W-1:0] r_shift, n_shift;
    logic [BCD_W-1:0]   r_bcd,   n_bcd;
    logic               r_neg,   n_neg;
    logic [CNT_W-1:0]   r_cnt,   n_cnt;
    logic [IDX_W-1:0]   r_idx,   n_idx;

    logic [BCD_W-1:0]   bcd_adj;
    logic [IDX_W-1:0]   lead_idx;
    logic [3:0]         cur_digit;

    // Add 3 to every BCD digit of five or more before the shift.
    always_comb begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                bcd_adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    // Position of the most significant nonzero digit; zero maps to digit 0.
    always_comb begin
        lead_idx = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] != 4'd0) begin
                lead_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_shift = r_shift;
        n_bcd   = r_bcd;
        n_neg   = r_neg;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        if (i_cmd.load) begin
            n_neg   = i_value[VALUE_W-1];
            n_shift = i_value[VALUE_W-1] ? (VALUE_W'(0) - i_value) : i_value;
            n_bcd   = '0;
            n_cnt   = '0;
        end else if (i_cmd.step) begin
            n_bcd   = {bcd_adj[BCD_W-2:0], r_shift[VALUE_W-1]};
            n_shift = {r_shift[VALUE_W-2:0], 1'b0};
            n_cnt   = r_cnt + CNT_W'(1);
        end else if (i_cmd.locate) begin
            n_idx   = lead_idx;
        end else if (i_cmd.emit_digit) begin
            n_idx   = r_idx - IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_bcd   <= n_bcd;
        r_neg   <= n_neg;
        r_cnt   <= n_cnt;
        r_idx   <= n_idx;
    end

    assign cur_digit = r_bcd[{r_idx, 2'b00} +: 4];

    assign o_char_code = i_cmd.emit_sign ? CHAR_MINUS : (CHAR_ZERO + {2'b00, cur_digit});
    assign o_last      = i_cmd.emit_digit && (r_idx == '0);

    assign o_status.conv_done = (r_cnt == LAST_STEP);
    assign o_status.is_neg    = r_neg;
    assign o_status.idx_zero  = (r_idx == '0);

endmodule

FILE: rtl/s2da_ctrl.sv
`timescale 1ns / 1ps

module s2da_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    output logic                  o_valid,
    input  s2da_pkg::t_dp_status  i_status,
    output s2da_pkg::t_dp_cmd     o_cmd
);
    import s2da_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) n_state = ST_CONVERT;
            end
            ST_CONVERT: begin
                if (i_status.conv_done) n_state = ST_LOCATE;
            end
            ST_LOCATE: begin
                n_state = i_status.is_neg ? ST_SIGN : ST_DIGITS;
            end
            ST_SIGN: begin
                n_state = ST_DIGITS;
            end
            ST_DIGITS: begin
                if (i_status.idx_zero) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        busy    = 1'b1;
        o_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            ST_CONVERT: begin
                o_cmd.step = 1'b1;
            end
            ST_LOCATE: begin
                o_cmd.locate = 1'b1;
            end
            ST_SIGN: begin
                o_cmd.emit_sign = 1'b1;
                o_valid         = 1'b1;
            end
            ST_DIGITS: begin
                o_cmd.emit_digit = 1'b1;
                o_valid          = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

FILE: rtl/signed_int_to_decimal_ascii_unit.sv
`timescale 1ns / 1ps
// An accepted item runs through the 32 shift-add-3 steps of the binary-to-BCD converter,
// then a locate state that finds the leading digit, then gives one character per cycle,
// 1 to 11 in all.
// A new item is accepted only in idle, after the last character of the previous item.
// Reset: synchronous, active low; returns the controller to idle with busy low.
module signed_int_to_decimal_ascii_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [s2da_pkg::VALUE_W-1:0] i_value,
    output logic                          o_valid,
    output logic [s2da_pkg::CHAR_W-1:0]   o_char_code,
    output logic                          o_last
);
    import s2da_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    s2da_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .o_valid  (o_valid),
        .i_status (dp_status),
        .o_cmd    (dp_cmd)
    );

    s2da_datapath u_datapath (
        .i_clk       (i_clk),
        .i_value     (i_value),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

    // A character only ever leaves while an item is in flight.
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("character strobe while idle");

    // The last flag marks a strobed character.
    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_valid)
        else $error("last flag without a character");

    // After the final character the unit is idle again.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> (!o_valid && !busy))
        else $error("unit not idle after last character");

    // An accepted item keeps the unit busy through conversion.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_valid))
        else $error("accepted item did not start conversion");

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import s2da_pkg::*;

    localparam int RESET_CYCLES = 5;
    localparam int RANDOM_ITEMS = 250;
    localparam int TAIL_CYCLES  = 60;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct {
        logic [CHAR_W-1:0] char_code;
        logic              last;
    } t_text_char;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic signed [VALUE_W-1:0] i_value;
    logic                      o_valid;
    logic [CHAR_W-1:0]         o_char_code;
    logic                      o_last;

    logic signed [VALUE_W-1:0] value_queue[$];
    t_text_char                expected_chars[$];
    logic                      item_taken;
    int                        gap_left;
    int                        error_count;
    int                        cycle_count;

    signed_int_to_decimal_ascii_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .o_char_code (o_char_code),
        .o_last      (o_last)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    task automatic report_mismatch(input string msg);
        $display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Appends the decimal text of one value to the expected characters.
    task automatic push_decimal_text(input logic signed [VALUE_W-1:0] value);
        logic [VALUE_W-1:0] magnitude;
        logic [3:0]         digits[NUM_DIGITS];
        int                 count;
        t_text_char         c;
        begin
            magnitude = value[VALUE_W-1] ? VALUE_W'(0) - value : value;
            count = 0;
            do begin
                digits[count] = 4'(magnitude % 10);
                magnitude = magnitude / 10;
                count++;
            end while (magnitude != 0 && count < NUM_DIGITS);
            if (value[VALUE_W-1]) begin
                c.char_code = CHAR_MINUS;
                c.last      = 1'b0;
                expected_chars.push_back(c);
            end
            for (int k = count - 1; k >= 0; k--) begin
                c.char_code = CHAR_ZERO + CHAR_W'(digits[k]);
                c.last      = (k == 0);
                expected_chars.push_back(c);
            end
        end
    endtask

    function automatic int pick_gap();
        int r;
        begin
            r = $urandom_range(0, 19);
            if (r < 10) begin
                return 0;
            end else if (r < 17) begin
                return $urandom_range(1, 4);
            end
            return $urandom_range(20, 90);
        end
    endfunction

    function automatic longint power_of_ten(input int n);
        longint p;
        begin
            p = 1;
            for (int k = 0; k < n; k++) begin
                p = p * 10;
            end
            return p;
        end
    endfunction

    // Values spread over every digit count, plus boundaries and raw bit patterns.
    function automatic logic signed [VALUE_W-1:0] random_value();
        int     mode;
        int     nd;
        longint lo;
        longint hi;
        longint v;
        begin
            mode = $urandom_range(0, 9);
            case (mode)
                0, 1, 2: begin
                    v = longint'($urandom);
                end
                7: begin
                    v = power_of_ten($urandom_range(0, 9)) + $urandom_range(0, 2) - 1;
                    if ($urandom_range(0, 1) == 1) begin
                        v = -v;
                    end
                end
                8: begin
                    if ($urandom_range(0, 1) == 1) begin
                        v = 64'sd2147483647 - $urandom_range(0, 5);
                    end else begin
                        v = -64'sd2147483648 + $urandom_range(0, 5);
                    end
                end
                9: begin
                    v = longint'($urandom_range(0, 40)) - 20;
                end
                default: begin
                    nd = $urandom_range(1, NUM_DIGITS);
                    lo = (nd == 1) ? 0 : power_of_ten(nd - 1);
                    hi = (nd == NUM_DIGITS) ? 64'sd2147483647 : power_of_ten(nd) - 1;
                    v = lo + (longint'($urandom) % (hi - lo + 1));
                    if ($urandom_range(0, 1) == 1) begin
                        v = -v;
                    end
                end
            endcase
            return VALUE_W'(v);
        end
    endfunction

    // Driver: start is held until the item is taken, then dropped for the chosen gap.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !item_taken) begin
            start <= 1'b1;
        end else if (gap_left > 0) begin
            start <= 1'b0;
            gap_left--;
        end else if (value_queue.size() > 0) begin
            i_value  <= value_queue.pop_front();
            start    <= 1'b1;
            gap_left = pick_gap();
        end else begin
            start <= 1'b0;
        end
    end

    // Monitor: predicts on every accepted item and checks every character.
    always @(posedge i_clk) begin
        t_text_char want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else if (i_rst_n) begin
            if (start && !busy) begin
                push_decimal_text(i_value);
                item_taken <= 1'b1;
            end else begin
                item_taken <= 1'b0;
            end
            if (o_valid) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch($sformatf("unexpected character %0d", o_char_code));
                end else begin
                    want = expected_chars.pop_front();
                    if (o_char_code !== want.char_code) begin
                        report_mismatch($sformatf("char_code %0d, expected %0d",
                                                  o_char_code, want.char_code));
                    end
                    if (o_last !== want.last) begin
                        report_mismatch($sformatf("last %0b, expected %0b",
                                                  o_last, want.last));
                    end
                end
            end
        end else begin
            item_taken <= 1'b0;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_value     = '0;
        item_taken  = 1'b0;
        gap_left    = 0;
        error_count = 0;
        cycle_count = 0;

        // Directed values: zero, single digits, decade edges, extremes and bit patterns.
        value_queue.push_back(32'sd0);
        value_queue.push_back(32'sd1);
        value_queue.push_back(-32'sd1);
        value_queue.push_back(32'sd9);
        value_queue.push_back(32'sd10);
        value_queue.push_back(-32'sd10);
        value_queue.push_back(32'sd99);
        value_queue.push_back(32'sd100);
        value_queue.push_back(-32'sd909);
        value_queue.push_back(32'sd999999999);
        value_queue.push_back(32'sd1000000000);
        value_queue.push_back(-32'sd999999999);
        value_queue.push_back(-32'sd1000000000);
        value_queue.push_back(32'sd1999999999);
        value_queue.push_back(32'sd2147483647);
        value_queue.push_back(32'sd2147483646);
        value_queue.push_back(-32'sd2147483647);
        value_queue.push_back(32'h80000000);
        value_queue.push_back(32'h55555555);
        value_queue.push_back(32'hAAAAAAAA);
        value_queue.push_back(32'sd1234567890);
        value_queue.push_back(32'sd0);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            value_queue.push_back(random_value());
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (value_queue.size() > 0 || start || expected_chars.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0 && expected_chars.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
